>>> rtl/core/mdf_pkg.sv
// Shared types and constants for the mesh duplicate filter and forwarder.
`default_nettype none

package mdf_pkg;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;
  localparam int KEY_W      = 40;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOC_TYPE     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HB_TYPE      = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTES = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_LOC_MIN      = CFG_IDX_W'(3);

  // Configuration reset values
  localparam logic [CFG_DATA_W-1:0] RST_LOC_TYPE     = 8'd1;
  localparam logic [CFG_DATA_W-1:0] RST_HB_TYPE      = 8'd2;
  localparam logic [CFG_DATA_W-1:0] RST_HEADER_BYTES = 8'd7;
  localparam logic [CFG_DATA_W-1:0] RST_LOC_MIN      = 8'd16;

  // Verdict codes
  localparam logic [1:0] VERDICT_SHORT = 2'd0;
  localparam logic [1:0] VERDICT_DUP   = 2'd1;
  localparam logic [1:0] VERDICT_NEW   = 2'd2;

  typedef struct packed {
    logic [31:0] device_id;
    logic [7:0]  message_id;
    logic [7:0]  hop_count;
    logic [7:0]  packet_type;
    logic [7:0]  packet_length;
    logic        uplink_up;
  } mdf_item_t;

  typedef struct packed {
    logic [1:0] verdict;
    logic       send_ack;
    logic       store_location;
    logic       upload;
    logic       forward;
    logic [7:0] forward_hops;
    logic       ttl_expired;
  } mdf_result_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] loc_type;
    logic [CFG_DATA_W-1:0] hb_type;
    logic [CFG_DATA_W-1:0] header_bytes;
    logic [CFG_DATA_W-1:0] loc_min_bytes;
  } mdf_cfg_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic commit;
  } mdf_cmd_t;

  typedef struct packed {
    logic too_short;
    logic issue_done;
    logic rd_pending;
    logic out_free;
  } mdf_sts_t;

endpackage

`default_nettype wire

>>> rtl/core/mdf_if.sv
// Handshake channel interfaces for the input, result and configuration ports.
`default_nettype none

interface mdf_in_if;
  import mdf_pkg::*;
  logic        valid;
  logic        ready;
  logic [31:0] device_id;
  logic [7:0]  message_id;
  logic [7:0]  hop_count;
  logic [7:0]  packet_type;
  logic [7:0]  packet_length;
  logic        uplink_up;

  modport source (output valid, device_id, message_id, hop_count, packet_type,
                  packet_length, uplink_up, input ready);
  modport sink (input valid, device_id, message_id, hop_count, packet_type,
                packet_length, uplink_up, output ready);
endinterface

interface mdf_out_if;
  import mdf_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;
  logic       send_ack;
  logic       store_location;
  logic       upload;
  logic       forward;
  logic [7:0] forward_hops;
  logic       ttl_expired;

  modport source (output valid, verdict, send_ack, store_location, upload, forward,
                  forward_hops, ttl_expired, input ready);
  modport sink (input valid, verdict, send_ack, store_location, upload, forward,
                forward_hops, ttl_expired, output ready);
endinterface

interface mdf_cfg_if;
  import mdf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

>>> rtl/core/mdf_cfg_regs.sv
// Configuration register bank: type codes and length thresholds.
`default_nettype none

module mdf_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          wr_en,
  input  wire logic [mdf_pkg::CFG_IDX_W-1:0]  wr_index,
  input  wire logic [mdf_pkg::CFG_DATA_W-1:0] wr_data,
  output mdf_pkg::mdf_cfg_t                  cfg
);
  import mdf_pkg::*;

  mdf_cfg_t cfg_r;
  mdf_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_LOC_TYPE:     cfg_nxt.loc_type      = wr_data;
        REG_HB_TYPE:      cfg_nxt.hb_type       = wr_data;
        REG_HEADER_BYTES: cfg_nxt.header_bytes  = wr_data;
        REG_LOC_MIN:      cfg_nxt.loc_min_bytes = wr_data;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.loc_type      <= RST_LOC_TYPE;
      cfg_r.hb_type       <= RST_HB_TYPE;
      cfg_r.header_bytes  <= RST_HEADER_BYTES;
      cfg_r.loc_min_bytes <= RST_LOC_MIN;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> rtl/core/mdf_ctrl.sv
// Controller: sequences accept, cache scan and result hand-off.
`default_nettype none

module mdf_ctrl (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire mdf_pkg::mdf_sts_t sts,
  output mdf_pkg::mdf_cmd_t cmd
);
  import mdf_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.too_short) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.rd = !sts.issue_done;
          // leave once every filled entry is read and the last compare is in
          if (sts.issue_done && !sts.rd_pending) begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/mdf_datapath.sv
// Datapath: item register, seen-pair cache memory, scan compare and verdict logic.
`default_nettype none

module mdf_datapath #(
  parameter int CACHE_DEPTH = 64
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire mdf_pkg::mdf_cmd_t  cmd,
  input  wire mdf_pkg::mdf_item_t item_in,
  input  wire mdf_pkg::mdf_cfg_t  cfg,
  input  wire logic          out_ready,
  output mdf_pkg::mdf_sts_t  sts,
  output mdf_pkg::mdf_result_t result,
  output logic               out_valid
);
  import mdf_pkg::*;

  localparam int PW = $clog2(CACHE_DEPTH);
  localparam int FW = $clog2(CACHE_DEPTH + 1);

  logic [KEY_W-1:0] seen_mem [CACHE_DEPTH];

  mdf_item_t        item_r;
  logic             too_short_r;
  logic [FW-1:0]    addr_r;
  logic             rd_vld_r;
  logic [KEY_W-1:0] rd_data_r;
  logic             hit_r;
  logic [PW-1:0]    ptr_r;
  logic [PW-1:0]    ptr_nxt;
  logic [FW-1:0]    fill_r;
  logic [FW-1:0]    fill_nxt;
  mdf_result_t      res_r;
  mdf_result_t      res_nxt;
  logic             out_valid_r;

  logic [KEY_W-1:0] key;
  logic             is_new;
  logic             is_loc;
  logic             is_hb;
  logic             want_fwd;

  assign key    = {item_r.device_id, item_r.message_id};
  assign is_new = !too_short_r && !hit_r;

  // Ring pointer wraps at the cache depth; fill count saturates there
  assign ptr_nxt  = (ptr_r == PW'(CACHE_DEPTH - 1)) ? '0 : ptr_r + PW'(1);
  assign fill_nxt = (fill_r == FW'(CACHE_DEPTH)) ? fill_r : fill_r + FW'(1);

  always_ff @(posedge clk) begin
    if (cmd.commit && is_new) begin
      seen_mem[ptr_r] <= key;
    end
    if (cmd.rd) begin
      rd_data_r <= seen_mem[addr_r[PW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r      <= item_in;
      too_short_r <= item_in.packet_length < cfg.header_bytes;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r      <= '0;
      rd_vld_r    <= 1'b0;
      hit_r       <= 1'b0;
      ptr_r       <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd;
      if (cmd.load) begin
        addr_r <= '0;
        hit_r  <= 1'b0;
      end else begin
        if (cmd.rd) begin
          addr_r <= addr_r + FW'(1);
        end
        if (rd_vld_r && rd_data_r == key) begin
          hit_r <= 1'b1;
        end
      end
      if (cmd.commit && is_new) begin
        ptr_r  <= ptr_nxt;
        fill_r <= fill_nxt;
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Verdict and forwarding decision for the held item
  always_comb begin
    res_nxt  = '0;
    is_loc   = item_r.packet_type == cfg.loc_type;
    is_hb    = item_r.packet_type == cfg.hb_type;
    want_fwd = 1'b0;
    if (too_short_r) begin
      res_nxt.verdict = VERDICT_SHORT;
    end else if (hit_r) begin
      res_nxt.verdict = VERDICT_DUP;
    end else begin
      res_nxt.verdict  = VERDICT_NEW;
      res_nxt.send_ack = is_loc || is_hb;
      if (is_loc) begin
        if (item_r.packet_length >= cfg.loc_min_bytes) begin
          res_nxt.store_location = 1'b1;
          res_nxt.upload         = item_r.uplink_up;
          want_fwd               = !item_r.uplink_up;
        end
      end else begin
        want_fwd = !item_r.uplink_up;
      end
      if (want_fwd) begin
        if (item_r.hop_count != 8'd0) begin
          res_nxt.forward      = 1'b1;
          res_nxt.forward_hops = item_r.hop_count - 8'd1;
        end else begin
          res_nxt.ttl_expired = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_r <= res_nxt;
    end
  end

  assign sts.too_short  = too_short_r;
  assign sts.issue_done = addr_r == fill_r;
  assign sts.rd_pending = rd_vld_r;
  assign sts.out_free   = !out_valid_r || out_ready;

  assign result    = res_r;
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

>>> rtl/core/mesh_duplicate_filter_forwarder.sv
// Mesh duplicate filter and forwarder: top level.
//
// Input channel (in_ch): one received packet header plus the uplink state per
// transfer. Result channel (out_ch): exactly one verdict per input item, in
// order. Configuration channel (cfg_ch): register index and data, always ready;
// write only while no item is in flight.
//
// Each item scans the cache of recent (device, message) pairs one entry per
// cycle through the single read port of the cache memory. The scan reads the
// fill entries written so far (fill is at most CACHE_DEPTH); with an empty
// cache, or for a packet shorter than the header, it reads none. One item is
// worked on at a time; the next is taken in the cycle after the current result
// is loaded into the output register, and a result may wait there while the
// next item scans.
// A new pair overwrites the oldest entry of the ring.
//
// Reset empties the cache (fill count and ring pointer to zero) and loads the
// register defaults. If the receiver stalls, the result is held and a
// finished scan waits until the output register is free.
`default_nettype none

module mesh_duplicate_filter_forwarder #(
  parameter int CACHE_DEPTH = 64
) (
  input wire logic clk,
  input wire logic rst_n,
  mdf_in_if.sink   in_ch,
  mdf_out_if.source out_ch,
  mdf_cfg_if.sink  cfg_ch
);
  import mdf_pkg::*;

  mdf_cfg_t    cfg;
  mdf_cmd_t    cmd;
  mdf_sts_t    sts;
  mdf_item_t   item;
  mdf_result_t result;
  logic        out_valid;

  assign item.device_id     = in_ch.device_id;
  assign item.message_id    = in_ch.message_id;
  assign item.hop_count     = in_ch.hop_count;
  assign item.packet_type   = in_ch.packet_type;
  assign item.packet_length = in_ch.packet_length;
  assign item.uplink_up     = in_ch.uplink_up;

  assign cfg_ch.ready = 1'b1;

  mdf_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.reg_index),
    .wr_data  (cfg_ch.wdata),
    .cfg      (cfg)
  );

  mdf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mdf_datapath #(
    .CACHE_DEPTH (CACHE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .item_in   (item),
    .cfg       (cfg),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .result    (result),
    .out_valid (out_valid)
  );

  assign out_ch.valid          = out_valid;
  assign out_ch.verdict        = result.verdict;
  assign out_ch.send_ack       = result.send_ack;
  assign out_ch.store_location = result.store_location;
  assign out_ch.upload         = result.upload;
  assign out_ch.forward        = result.forward;
  assign out_ch.forward_hops   = result.forward_hops;
  assign out_ch.ttl_expired    = result.ttl_expired;

endmodule

`default_nettype wire
